// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file.
// Each macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define LHF_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("link handshake check failed");

// Next-cycle implication
`define LHF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("link handshake check failed");

`endif

// ===== sv/lhf_pkg.sv =====
// Shared types and constants of the link handshake block.
// No dependencies; the design and checker files refer to it by scoped names.
package lhf_pkg;

    localparam int CODE_W  = 8;
    localparam int TIMER_W = 16;
    localparam int CMD_W   = 3;
    localparam int STATE_W = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CODE_W-1:0]  ALIVE_CODE_RST        = 8'd1;
    localparam logic [CODE_W-1:0]  CONNECTED_CODE_RST    = 8'd2;
    localparam logic [CODE_W-1:0]  DISCONNECTED_CODE_RST = 8'd3;
    localparam logic [TIMER_W-1:0] WAIT_TIMEOUT_RST      = 16'd100;

    typedef enum logic [STATE_W-1:0] {
        ST_DISCONNECTED = 3'd0,
        ST_START        = 3'd1,
        ST_WAIT         = 3'd2,
        ST_CONNECTED    = 3'd3,
        ST_DISCONNECT   = 3'd4
    } lhf_state_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_RUN        = 3'd0,
        CMD_TICK       = 3'd1,
        CMD_CONNECT    = 3'd2,
        CMD_DISCONNECT = 3'd3,
        CMD_RELINK     = 3'd4
    } lhf_cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ALIVE_CODE        = 2'd0,
        REG_CONNECTED_CODE    = 2'd1,
        REG_DISCONNECTED_CODE = 2'd2,
        REG_WAIT_TIMEOUT      = 2'd3
    } lhf_reg_idx_t;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic              link_up;
        logic              packet_valid;
        logic [CODE_W-1:0] packet_code;
    } lhf_req_t;

    typedef struct packed {
        logic [STATE_W-1:0] side_state;
        logic               link_ready;
        logic               connect_accepted;
        logic               packet_taken;
        logic               send_valid;
        logic [CODE_W-1:0]  send_code;
        logic               deliver_valid;
        logic [CODE_W-1:0]  deliver_code;
    } lhf_res_t;

    typedef struct packed {
        logic [CODE_W-1:0]  alive_code;
        logic [CODE_W-1:0]  connected_code;
        logic [CODE_W-1:0]  disconnected_code;
        logic [TIMER_W-1:0] wait_timeout_ms;
    } lhf_cfg_t;

endpackage

// ===== sv/lhf_cfg_regs.sv =====
// Configuration register file of the link handshake block.
// Depends on lhf_pkg for the register indexes, reset values and lhf_cfg_t.
module lhf_cfg_regs
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lhf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lhf_pkg::CFG_DATA_W-1:0]    cfg_data,
    output lhf_pkg::lhf_cfg_t                 cfg
);

    lhf_pkg::lhf_cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.alive_code        <= lhf_pkg::ALIVE_CODE_RST;
            cfg_reg.connected_code    <= lhf_pkg::CONNECTED_CODE_RST;
            cfg_reg.disconnected_code <= lhf_pkg::DISCONNECTED_CODE_RST;
            cfg_reg.wait_timeout_ms   <= lhf_pkg::WAIT_TIMEOUT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (lhf_pkg::lhf_reg_idx_t'(cfg_index))
                lhf_pkg::REG_ALIVE_CODE:
                    cfg_reg.alive_code <= cfg_data[lhf_pkg::CODE_W-1:0];
                lhf_pkg::REG_CONNECTED_CODE:
                    cfg_reg.connected_code <= cfg_data[lhf_pkg::CODE_W-1:0];
                lhf_pkg::REG_DISCONNECTED_CODE:
                    cfg_reg.disconnected_code <= cfg_data[lhf_pkg::CODE_W-1:0];
                lhf_pkg::REG_WAIT_TIMEOUT:
                    cfg_reg.wait_timeout_ms <= cfg_data[lhf_pkg::TIMER_W-1:0];
                default:
                    ;
            endcase
        end
    end

endmodule

// ===== sv/lhf_fsm.sv =====
// Handshake state machine: state, pending drop/relink flags and wait countdown.
// Depends on lhf_pkg; decides one request per cycle when fire is high.
module lhf_fsm
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  lhf_pkg::lhf_req_t req,
    input  lhf_pkg::lhf_cfg_t cfg,
    output lhf_pkg::lhf_res_t res
);

    lhf_pkg::lhf_state_t              state_reg, state_next;
    logic                             drop_reg, drop_next;
    logic                             relink_reg, relink_next;
    logic [lhf_pkg::TIMER_W-1:0]      wait_reg, wait_next;

    lhf_pkg::lhf_cmd_t cmd;
    logic              drop_cause;
    logic              timed_out;
    logic              is_connected_pkt;
    logic              is_alive_pkt;

    assign cmd              = lhf_pkg::lhf_cmd_t'(req.command);
    assign drop_cause       = drop_reg || relink_reg || !req.link_up;
    assign timed_out        = (wait_reg == '0);
    assign is_connected_pkt = req.packet_valid && (req.packet_code == cfg.connected_code);
    assign is_alive_pkt     = req.packet_valid && (req.packet_code == cfg.alive_code);

    // Next state
    always_comb
    begin
        state_next  = state_reg;
        drop_next   = drop_reg;
        relink_next = relink_reg;
        wait_next   = wait_reg;
        if (fire)
        begin
            case (cmd)
                lhf_pkg::CMD_RUN:
                begin
                    case (state_reg)
                        lhf_pkg::ST_START:
                        begin
                            if (drop_cause)
                            begin
                                state_next  = lhf_pkg::ST_DISCONNECTED;
                                drop_next   = 1'b0;
                                relink_next = 1'b0;
                            end
                            else
                            begin
                                state_next = lhf_pkg::ST_WAIT;
                                wait_next  = cfg.wait_timeout_ms;
                            end
                        end
                        lhf_pkg::ST_WAIT:
                        begin
                            if (drop_cause)
                            begin
                                state_next  = lhf_pkg::ST_DISCONNECTED;
                                drop_next   = 1'b0;
                                relink_next = 1'b0;
                            end
                            else if (timed_out)
                                state_next = lhf_pkg::ST_START;
                            else if (is_connected_pkt)
                                state_next = lhf_pkg::ST_CONNECTED;
                        end
                        lhf_pkg::ST_CONNECTED:
                        begin
                            if (drop_cause)
                                state_next = lhf_pkg::ST_DISCONNECT;
                            else if (is_alive_pkt)
                                state_next = lhf_pkg::ST_START;
                        end
                        lhf_pkg::ST_DISCONNECT:
                        begin
                            state_next  = lhf_pkg::ST_DISCONNECTED;
                            drop_next   = 1'b0;
                            relink_next = 1'b0;
                        end
                        default:
                            ;
                    endcase
                end
                lhf_pkg::CMD_TICK:
                begin
                    if (!timed_out)
                        wait_next = wait_reg - 1'b1;
                end
                lhf_pkg::CMD_CONNECT:
                begin
                    if (state_reg == lhf_pkg::ST_DISCONNECTED && req.link_up)
                    begin
                        state_next  = lhf_pkg::ST_START;
                        drop_next   = 1'b0;
                        relink_next = 1'b0;
                    end
                end
                lhf_pkg::CMD_DISCONNECT:
                begin
                    if (state_reg != lhf_pkg::ST_DISCONNECTED)
                        drop_next = 1'b1;
                end
                lhf_pkg::CMD_RELINK:
                    relink_next = 1'b1;
                default:
                    ;
            endcase
        end
    end

    // Result of the request under decision
    always_comb
    begin
        res                  = '0;
        res.side_state       = state_next;
        res.link_ready       = (state_next == lhf_pkg::ST_CONNECTED) && req.link_up;
        case (cmd)
            lhf_pkg::CMD_RUN:
            begin
                case (state_reg)
                    lhf_pkg::ST_START:
                    begin
                        if (!drop_cause)
                        begin
                            res.send_valid = 1'b1;
                            res.send_code  = cfg.alive_code;
                        end
                    end
                    lhf_pkg::ST_WAIT:
                    begin
                        if (!drop_cause && !timed_out && req.packet_valid)
                        begin
                            res.packet_taken = 1'b1;
                            if (is_connected_pkt)
                            begin
                                res.send_valid    = 1'b1;
                                res.send_code     = cfg.connected_code;
                                res.deliver_valid = 1'b1;
                                res.deliver_code  = req.packet_code;
                            end
                        end
                    end
                    lhf_pkg::ST_CONNECTED:
                    begin
                        if (!drop_cause && req.packet_valid)
                        begin
                            res.packet_taken = 1'b1;
                            if (!is_alive_pkt)
                            begin
                                res.deliver_valid = 1'b1;
                                res.deliver_code  = req.packet_code;
                            end
                        end
                    end
                    lhf_pkg::ST_DISCONNECT:
                    begin
                        res.deliver_valid = 1'b1;
                        res.deliver_code  = cfg.disconnected_code;
                    end
                    default:
                        ;
                endcase
            end
            lhf_pkg::CMD_CONNECT:
                res.connect_accepted = (state_reg == lhf_pkg::ST_DISCONNECTED) && req.link_up;
            default:
                ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= lhf_pkg::ST_DISCONNECTED;
            drop_reg   <= 1'b0;
            relink_reg <= 1'b0;
            wait_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            drop_reg   <= drop_next;
            relink_reg <= relink_next;
            wait_reg   <= wait_next;
        end
    end

endmodule

// ===== sv/link_handshake_fsm.sv =====
// Top level of the link handshake block: request register, state machine, result register.
// Depends on lhf_pkg, lhf_cfg_regs and lhf_fsm.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+-------------------------------
//   req      | req_valid / req_stall   | req (lhf_req_t)
//   res      | res_valid / res_stall   | res (lhf_res_t), one per request
//   cfg      | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// One request per cycle while res is not stalled: a request is held in the request
// register, is decided by the state machine and lands in the result register.
// Reset clears the state, the flags, the countdown and both valid bits and loads the
// register defaults. A stall on res holds the result register and backs up into the
// request register; req_stall rises only while both are full and res is stalled.
module link_handshake_fsm
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_stall,
    input  lhf_pkg::lhf_req_t              req,
    output logic                           res_valid,
    input  logic                           res_stall,
    output lhf_pkg::lhf_res_t              res,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [lhf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lhf_pkg::CFG_DATA_W-1:0] cfg_data
);

    lhf_pkg::lhf_cfg_t cfg;
    lhf_pkg::lhf_req_t req_q_reg;
    logic              req_q_valid_reg, req_q_valid_next;
    lhf_pkg::lhf_res_t res_reg;
    logic              res_valid_reg, res_valid_next;
    lhf_pkg::lhf_res_t fsm_res;
    logic              fire;
    logic              req_take;

    lhf_cfg_regs u_cfg_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lhf_fsm u_fsm
    (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .req   (req_q_reg),
        .cfg   (cfg),
        .res   (fsm_res)
    );

    // Advance the held request when the result register is free or being emptied
    assign fire      = req_q_valid_reg && (!res_valid_reg || !res_stall);
    assign req_stall = req_q_valid_reg && !fire;
    assign req_take  = req_valid && !req_stall;

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_comb
    begin
        req_q_valid_next = req_take || (req_q_valid_reg && !fire);
        res_valid_next   = fire || (res_valid_reg && res_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_q_valid_reg <= 1'b0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            req_q_valid_reg <= req_q_valid_next;
            res_valid_reg   <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_take)
            req_q_reg <= req;
        if (fire)
            res_reg <= fsm_res;
    end

endmodule

// ===== sv/lhf_checker.sv =====
// Port-level checks of the link handshake block, bound to the top level.
// Depends on lhf_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lhf_checker
(
    input logic              clk,
    input logic              rst_n,
    input logic              req_stall,
    input logic              res_valid,
    input logic              res_stall,
    input lhf_pkg::lhf_res_t res
);

    // Ready only in the connected state
    `LHF_ASSERT_NOW(a_ready_connected, res_valid && res.link_ready,
                    res.side_state == lhf_pkg::ST_CONNECTED)

    // An accepted connect always lands in start
    `LHF_ASSERT_NOW(a_accept_start, res_valid && res.connect_accepted,
                    res.side_state == lhf_pkg::ST_START)

    // Codes read zero when nothing is sent or delivered
    `LHF_ASSERT_NOW(a_idle_codes, res_valid && !res.send_valid && !res.deliver_valid,
                    res.send_code == '0 && res.deliver_code == '0)

    // Hold a stalled result
    `LHF_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(res))

    // Hold requests back only behind a stalled result
    `LHF_ASSERT_NOW(a_stall_cause, req_stall, res_valid && res_stall)

endmodule

bind link_handshake_fsm lhf_checker u_lhf_checker (.*);
